// ===== hw/rtl/command_token_lexer_macros.svh =====
// assertion macros shared by the lexer rtl
`ifndef COMMAND_TOKEN_LEXER_MACROS_SVH
`define COMMAND_TOKEN_LEXER_MACROS_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define CTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define CTL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CTL_ASSERT(lbl, prop, msg)
`define CTL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/ctl_pkg.sv =====
// types, constants and keyword tables of the command token lexer
package ctl_pkg;

  localparam int unsigned DefMaxTokens = 3;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero  = "0";
  localparam logic [7:0] CharNine  = "9";
  localparam logic [7:0] CharUpA   = "A";
  localparam logic [7:0] CharUpF   = "F";
  localparam logic [7:0] CharX     = "x";
  localparam logic [3:0] HexTen    = 4'd10;

  localparam logic [2:0] PosMax    = 3'd7;
  localparam logic [2:0] PosHexLo  = 3'd2;
  localparam logic [2:0] PosHexHi  = 3'd5;
  localparam logic [2:0] NumPosMin = 3'd3;
  localparam logic [2:0] NumPosMax = 3'd6;

  localparam int unsigned KwCount = 3;
  localparam logic [KwCount-1:0] KwAllCand = '1;

  typedef enum logic [1:0] {
    KIND_KEYWORD = 2'd0,
    KIND_NUMBER  = 2'd1,
    KIND_STRING  = 2'd2
  } token_kind_e;

  typedef enum logic [1:0] {
    KW_LOAD  = 2'd0,
    KW_STORE = 2'd1,
    KW_RESET = 2'd2
  } kw_code_e;

  typedef struct packed {
    logic        token_valid;
    token_kind_e token_kind;
    kw_code_e    keyword_code;
    logic [15:0] number_value;
    logic [1:0]  token_index;
    logic        message_end;
    logic [1:0]  token_count;
  } ctl_result_t;

  function automatic logic [2:0] kw_len(kw_code_e code);
    logic [2:0] len;
    case (code)
      KW_LOAD:  len = 3'd4;
      KW_STORE: len = 3'd5;
      KW_RESET: len = 3'd5;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  // character of a keyword at a position, zero past its end
  function automatic logic [7:0] kw_char(kw_code_e code, logic [2:0] pos);
    logic [7:0] ch;
    ch = CharNul;
    case (code)
      KW_LOAD: begin
        case (pos)
          3'd0:    ch = "l";
          3'd1:    ch = "o";
          3'd2:    ch = "a";
          3'd3:    ch = "d";
          default: ch = CharNul;
        endcase
      end
      KW_STORE: begin
        case (pos)
          3'd0:    ch = "s";
          3'd1:    ch = "t";
          3'd2:    ch = "o";
          3'd3:    ch = "r";
          3'd4:    ch = "e";
          default: ch = CharNul;
        endcase
      end
      KW_RESET: begin
        case (pos)
          3'd0:    ch = "r";
          3'd1:    ch = "e";
          3'd2:    ch = "s";
          3'd3:    ch = "e";
          3'd4:    ch = "t";
          default: ch = CharNul;
        endcase
      end
      default: ch = CharNul;
    endcase
    return ch;
  endfunction

  function automatic logic kw_hit(kw_code_e code, logic [2:0] pos, logic [7:0] ch);
    return (pos < kw_len(code)) && (kw_char(code, pos) == ch);
  endfunction

endpackage

// ===== hw/rtl/ctl_core.sv =====
// lexer state and per-character token classification
`include "command_token_lexer_macros.svh"

module ctl_core #(
  parameter int unsigned MaxTokens = ctl_pkg::DefMaxTokens
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [7:0]          char_i,
  output logic                res_vld_o,
  output ctl_pkg::ctl_result_t res_o
);
  import ctl_pkg::*;

  localparam int unsigned TsW = $clog2(MaxTokens + 1);

  logic               inside_q, inside_d;
  logic [TsW-1:0]     ts_q, ts_d;
  logic [2:0]         pos_q, pos_d;
  logic [KwCount-1:0] cand_q, cand_d;
  logic [15:0]        acc_q, acc_d;
  logic               hv_q, hv_d;

  logic               is_end, is_sp, start, take, tok_end;
  logic [2:0]         pos_e;
  logic [KwCount-1:0] cand_e, cand_n;
  logic [15:0]        acc_e, acc_n;
  logic               hv_e, hv_n;
  logic [3:0]         digit;
  logic               digit_ok;
  logic [TsW+1:0]     ts_ext, ts_m1;
  logic               kw_found;
  kw_code_e           kw_sel;

  assign is_end  = (char_i == CharNul);
  assign is_sp   = (char_i == CharSpace);
  assign start   = !inside_q && !is_end && !is_sp && (ts_q < TsW'(MaxTokens));
  assign take    = !is_end && !is_sp && (inside_q || start);
  assign tok_end = inside_q && (is_end || is_sp);

  // a new token starts from cleared token state
  assign pos_e  = start ? 3'd0 : pos_q;
  assign cand_e = start ? KwAllCand : cand_q;
  assign acc_e  = start ? 16'd0 : acc_q;
  assign hv_e   = start ? 1'b1 : hv_q;

  always_comb begin
    digit    = 4'd0;
    digit_ok = 1'b1;
    if (char_i >= CharZero && char_i <= CharNine) begin
      digit = 4'(char_i - CharZero);
    end else if (char_i >= CharUpA && char_i <= CharUpF) begin
      digit = 4'(char_i - CharUpA) + HexTen;
    end else begin
      digit_ok = 1'b0;
    end
  end

  always_comb begin
    cand_n = cand_e;
    for (int k = 0; k < KwCount; k++) begin
      if (!kw_hit(kw_code_e'(2'(k)), pos_e, char_i)) begin
        cand_n[k] = 1'b0;
      end
    end
    acc_n = acc_e;
    hv_n  = hv_e;
    if (pos_e == 3'd0) begin
      if (char_i != CharZero) hv_n = 1'b0;
    end else if (pos_e == 3'd1) begin
      if (char_i != CharX) hv_n = 1'b0;
    end else if (pos_e >= PosHexLo && pos_e <= PosHexHi) begin
      if (!digit_ok) hv_n = 1'b0;
      acc_n = {acc_e[11:0], digit};
    end else begin
      hv_n = 1'b0;
    end
  end

  // keyword match, lowest code first
  always_comb begin
    kw_found = 1'b0;
    kw_sel   = KW_LOAD;
    for (int k = KwCount - 1; k >= 0; k--) begin
      if (cand_q[k] && pos_q == kw_len(kw_code_e'(2'(k)))) begin
        kw_found = 1'b1;
        kw_sel   = kw_code_e'(2'(k));
      end
    end
  end

  assign ts_ext = {2'b00, ts_q};
  assign ts_m1  = ts_ext - 1'b1;

  always_comb begin
    res_o = '0;
    if (tok_end) begin
      res_o.token_valid = 1'b1;
      res_o.token_index = ts_m1[1:0];
      if (kw_found) begin
        res_o.token_kind   = KIND_KEYWORD;
        res_o.keyword_code = kw_sel;
      end else if (hv_q && pos_q >= NumPosMin && pos_q <= NumPosMax) begin
        res_o.token_kind   = KIND_NUMBER;
        res_o.number_value = acc_q;
      end else begin
        res_o.token_kind = KIND_STRING;
      end
    end
    if (is_end) begin
      res_o.message_end = 1'b1;
      res_o.token_count = ts_ext[1:0];
    end
  end

  assign res_vld_o = adv_i && (is_end || tok_end);

  always_comb begin
    inside_d = inside_q;
    ts_d     = ts_q;
    pos_d    = pos_q;
    cand_d   = cand_q;
    acc_d    = acc_q;
    hv_d     = hv_q;
    if (adv_i) begin
      if (is_end || tok_end) begin
        inside_d = 1'b0;
        pos_d    = 3'd0;
        cand_d   = KwAllCand;
        acc_d    = 16'd0;
        hv_d     = 1'b1;
        if (is_end) ts_d = '0;
      end else if (take) begin
        inside_d = 1'b1;
        if (start) ts_d = ts_q + 1'b1;
        pos_d    = (pos_e < PosMax) ? pos_e + 3'd1 : pos_e;
        cand_d   = cand_n;
        acc_d    = acc_n;
        hv_d     = hv_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      ts_q     <= '0;
      pos_q    <= 3'd0;
      cand_q   <= KwAllCand;
      acc_q    <= 16'd0;
      hv_q     <= 1'b1;
    end else begin
      inside_q <= inside_d;
      ts_q     <= ts_d;
      pos_q    <= pos_d;
      cand_q   <= cand_d;
      acc_q    <= acc_d;
      hv_q     <= hv_d;
    end
  end

  `CTL_ASSERT(end_clears_count, adv_i && is_end |=> ts_q == '0, "count not cleared at message end")
  `CTL_ASSERT(start_counts_token, $rose(inside_q) |-> ts_q == $past(ts_q) + 1'b1, "token started without count")
  `CTL_ASSERT(count_in_range, ts_q <= TsW'(MaxTokens), "token count above limit")

endmodule

// ===== hw/rtl/ctl_res_buf.sv =====
// two-entry result buffer between the lexer core and the output stream
`include "command_token_lexer_macros.svh"

module ctl_res_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ctl_pkg::ctl_result_t data_i,
  output logic                space_o,
  output logic                vld_o,
  input  logic                rdy_i,
  output ctl_pkg::ctl_result_t data_o
);
  import ctl_pkg::*;

  localparam logic [1:0] BufFull = 2'd2;

  ctl_result_t mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  assign space_o = (cnt_q != BufFull);
  assign vld_o   = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = vld_o && rdy_i;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `CTL_ASSERT(no_push_when_full, push_i |-> cnt_q != BufFull, "request pushed into full buffer")
  `CTL_ASSERT_ALWAYS(ptr_gap_matches_count, (cnt_q == BufFull) || (cnt_q == 2'd0) ? wr_ptr_q == rd_ptr_q : wr_ptr_q != rd_ptr_q, "buffer pointers out of step")

endmodule

// ===== hw/rtl/command_token_lexer.sv =====
// command token lexer: splits a character stream into classified tokens
// Takes one character per cycle and keeps that rate indefinitely while the output side
// is ready; a character passes an input register, the lexer state update and
// classification, and its report is held in a two-entry result buffer for the output.
// Spaces end tokens and a zero byte ends the message; only those characters produce a
// request on the output, which carries the token report (kind, keyword code or hex value,
// index) and, at message end, tlast and the token count. Tokens beyond MaxTokens in one
// message are dropped.
module command_token_lexer #(
  parameter int unsigned MaxTokens = ctl_pkg::DefMaxTokens
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] token_valid, [2:1] keyword_code, [18:3] number_value,
  // [20:19] token_index, [22:21] token_count, [23] zero
  output logic [23:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // [1:0] token_kind
  output logic        m_axis_tlast_o    // message_end
);
  import ctl_pkg::*;

  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_char_q;
  logic        adv, space, res_vld;
  ctl_result_t res, head;

  assign adv             = in_vld_q && space;
  assign s_axis_tready_o = !in_vld_q || adv;
  assign in_vld_d        = s_axis_tready_o ? s_axis_tvalid_i : in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) in_char_q <= s_axis_tdata_i;
  end

  ctl_core #(
    .MaxTokens(MaxTokens)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .char_i   (in_char_q),
    .res_vld_o(res_vld),
    .res_o    (res)
  );

  ctl_res_buf u_res_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_vld),
    .data_i (res),
    .space_o(space),
    .vld_o  (m_axis_tvalid_o),
    .rdy_i  (m_axis_tready_i),
    .data_o (head)
  );

  assign m_axis_tdata_o = {1'b0, head.token_count, head.token_index, head.number_value,
                           head.keyword_code, head.token_valid};
  assign m_axis_tuser_o = head.token_kind;
  assign m_axis_tlast_o = head.message_end;

endmodule

// ===== bench/tb.sv =====
// testbench of the command token lexer: directed and random messages checked by a predictor
`timescale 1ns / 100ps

module tb;
  import ctl_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] char_code
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;    // [0] token_valid, [2:1] keyword_code, [18:3] number_value,
                                // [20:19] token_index, [22:21] token_count, [23] zero
  logic [1:0]  m_axis_tuser;    // [1:0] token_kind
  logic        m_axis_tlast;    // message_end

  command_token_lexer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  // lexer state as predicted from the accepted characters
  logic        in_token;
  logic [3:0]  tokens_open;
  logic [2:0]  char_pos;
  logic [2:0]  kw_alive;
  logic [15:0] hex_value;
  logic        hex_ok;

  string       kw_word [3] = '{"load", "store", "reset"};
  ctl_result_t token_reports_q [$];
  logic [7:0]  msg_q [$];
  int          error_count;
  int          chars_sent;
  bit          idle_en;
  int          out_stall_left;

  always #1 clk_i = ~clk_i;

  function automatic void clear_token();
    in_token  = 1'b0;
    char_pos  = 3'd0;
    kw_alive  = 3'b111;
    hex_value = 16'h0;
    hex_ok    = 1'b1;
  endfunction

  function automatic ctl_result_t token_report();
    ctl_result_t r;
    r = '0;
    r.token_valid = 1'b1;
    r.token_kind  = KIND_STRING;
    r.token_index = 2'(tokens_open - 4'd1);
    for (int k = 0; k < 3; k++) begin
      if (kw_alive[k] && char_pos == kw_word[k].len()) begin
        r.token_kind   = KIND_KEYWORD;
        r.keyword_code = kw_code_e'(k);
        return r;
      end
    end
    if (hex_ok && char_pos >= 3'd3 && char_pos <= 3'd6) begin
      r.token_kind   = KIND_NUMBER;
      r.number_value = hex_value;
    end
    return r;
  endfunction

  function automatic void add_to_token(logic [7:0] c);
    logic [3:0] digit;
    digit = 4'd0;
    for (int k = 0; k < 3; k++) begin
      if (char_pos >= kw_word[k].len() || kw_word[k][char_pos] != c) kw_alive[k] = 1'b0;
    end
    if (char_pos == 3'd0) begin
      if (c != CharZero) hex_ok = 1'b0;
    end else if (char_pos == 3'd1) begin
      if (c != CharX) hex_ok = 1'b0;
    end else if (char_pos <= 3'd5) begin
      if (c >= CharZero && c <= CharNine) digit = 4'(c - CharZero);
      else if (c >= CharUpA && c <= CharUpF) digit = 4'(c - CharUpA + 8'd10);
      else hex_ok = 1'b0;
      hex_value = {hex_value[11:0], digit};
    end else begin
      hex_ok = 1'b0;
    end
    if (char_pos != 3'd7) char_pos = char_pos + 3'd1;
  endfunction

  // advance the predicted lexer by one accepted character
  function automatic void lex_char(logic [7:0] c);
    ctl_result_t r;
    r = '0;
    if (c == CharNul) begin
      if (in_token) r = token_report();
      r.message_end = 1'b1;
      r.token_count = tokens_open[1:0];
      tokens_open = 4'd0;
      clear_token();
      token_reports_q.push_back(r);
    end else if (c == CharSpace) begin
      if (in_token) begin
        token_reports_q.push_back(token_report());
        clear_token();
      end
    end else begin
      if (!in_token && tokens_open < DefMaxTokens) begin
        clear_token();
        in_token = 1'b1;
        tokens_open = tokens_open + 4'd1;
      end
      if (in_token) add_to_token(c);
    end
  endfunction

  task automatic send_char(logic [7:0] c);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    lex_char(c);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained(int max_cycles);
    int n;
    n = 0;
    while (token_reports_q.size() != 0 && n < max_cycles) begin
      @(negedge clk_i);
      n++;
    end
  endtask

  function automatic logic [7:0] any_token_char();
    logic [7:0] c;
    c = 8'(($urandom_range(1, 254) + ((CharSpace == 8'd254) ? 0 : 0)));
    if (c == CharSpace) c = 8'hff;
    return c;
  endfunction

  // one message into msg_q: mostly well-formed tokens, sometimes raw noise
  task automatic build_message();
    int         ntok;
    int         len;
    string      hexdig;
    string      w;
    logic [7:0] c;
    hexdig = "0123456789ABCDEF";
    msg_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) msg_q.push_back(8'($urandom_range(0, 255)));
      msg_q.push_back(CharNul);
      return;
    end
    if ($urandom_range(0, 4) == 0) msg_q.push_back(CharSpace);
    ntok = $urandom_range(0, 5);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          w = kw_word[$urandom_range(0, 2)];
          len = w.len();
          if ($urandom_range(0, 3) == 0) len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) msg_q.push_back(i < w.len() ? w[i] : "e");
          if ($urandom_range(0, 7) == 0) msg_q[msg_q.size() - 1] = "L";
        end
        3, 4, 5: begin
          msg_q.push_back($urandom_range(0, 15) == 0 ? "1" : CharZero);
          msg_q.push_back($urandom_range(0, 15) == 0 ? "X" : CharX);
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 4);
          for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 11))
              0:       c = 8'($urandom_range(8'h21, 8'h7e));
              1:       c = 8'($urandom_range("a", "f"));
              default: c = hexdig[$urandom_range(0, 15)];
            endcase
            if (c == CharSpace) c = "G";
            msg_q.push_back(c);
          end
        end
        6, 7, 8: begin
          repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
        end
        default: begin
          repeat ($urandom_range(1, 8)) msg_q.push_back(any_token_char());
        end
      endcase
      repeat (($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 1) msg_q.push_back(CharSpace);
      if (t == ntok - 1 && $urandom_range(0, 1) == 0) void'(msg_q.pop_back());
    end
    msg_q.push_back(CharNul);
  endtask

  task automatic send_random_messages(int n_chars);
    int target;
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      build_message();
      foreach (msg_q[i]) send_char(msg_q[i]);
    end
  endtask

  // keywords and the token limit: the fourth token is dropped
  task automatic test_keywords();
    send_text("load store reset 0x1");
    send_char(CharNul);
  endtask

  // largest number ending with the message, an empty message, extreme characters
  task automatic test_numbers_and_extremes();
    send_text("0xFFFF");
    send_char(CharNul);
    send_char(CharNul);
    send_char(8'h01);
    send_char(8'hff);
    send_char(CharSpace);
    send_char(CharNul);
  endtask

  task automatic test_random_with_idling();
    idle_en = 1'b1;
    send_random_messages(300);
  endtask

  // sender holds off until every report is out, then carries on
  task automatic test_pause_until_drained();
    send_random_messages(20);
    stop_sending();
    wait_drained(10000);
    send_random_messages(280);
  endtask

  task automatic test_random_full_rate();
    idle_en = 1'b0;
    send_random_messages(150);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 100)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    ctl_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (token_reports_q.size() == 0) begin
        error_count++;
        if (error_count <= 100)
          $display("%0t: unexpected request, expected none, actual tdata %0h tuser %0h tlast %0b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = token_reports_q.pop_front();
        check_field("token_valid", 16'(want.token_valid), 16'(m_axis_tdata[0]));
        check_field("token_kind", 16'(want.token_kind), 16'(m_axis_tuser));
        check_field("keyword_code", 16'(want.keyword_code), 16'(m_axis_tdata[2:1]));
        check_field("number_value", want.number_value, m_axis_tdata[18:3]);
        check_field("token_index", 16'(want.token_index), 16'(m_axis_tdata[20:19]));
        check_field("message_end", 16'(want.message_end), 16'(m_axis_tlast));
        check_field("token_count", 16'(want.token_count), 16'(m_axis_tdata[22:21]));
      end
    end
  end

  // output stalls in random bursts, only while idling is enabled
  always @(negedge clk_i) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_stall_left = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #200000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    m_axis_tready  = 1'b0;
    idle_en        = 1'b1;
    out_stall_left = 0;
    error_count    = 0;
    chars_sent     = 0;
    tokens_open    = 4'd0;
    clear_token();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_keywords();
    test_numbers_and_extremes();
    test_random_with_idling();
    test_pause_until_drained();
    test_random_full_rate();

    stop_sending();
    wait_drained(10000);
    repeat (20) @(posedge clk_i);
    if (token_reports_q.size() != 0) begin
      error_count++;
      $display("%0t: missing requests, expected %0d more, actual none",
               $time, token_reports_q.size());
    end
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ctl_pkg.sv
hw/rtl/ctl_core.sv
hw/rtl/ctl_res_buf.sv
hw/rtl/command_token_lexer.sv
bench/tb.sv
